>>> rtl/pcbf_pkg.sv
// shared types, constants and codes of the point colour fusion block
package pcbf_pkg;

  localparam int POINT_COUNT = 4096;
  localparam int PT_AW       = $clog2(POINT_COUNT);

  localparam int IN_W   = 96;
  localparam int OUT_W  = 72;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] CFG_OBS_SIGMA  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_PROC_NOISE = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_GATE_RATIO = 2'd2;

  localparam logic [15:0] OBS_SIGMA_RST  = 16'd3840;
  localparam logic [15:0] PROC_NOISE_RST = 16'd26;
  localparam logic [9:0]  GATE_RATIO_RST = 10'd307;

  localparam logic [1:0] RES_REJECT = 2'd0;
  localparam logic [1:0] RES_FIRST  = 2'd1;
  localparam logic [1:0] RES_FUSED  = 2'd2;

  localparam int CHANNELS    = 3;
  localparam int COLOR_QBITS = 16;
  localparam int SIGMA_QBITS = 32;
  localparam int ROOT_BITS   = 16;

  typedef struct packed {
    logic [15:0]      count;
    logic [31:0]      last_time;
    logic [23:0]      near_dist;
    logic [2:0][15:0] sigma;
    logic [2:0][15:0] color;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [15:0] meas_sigma;
    logic [15:0] proc_noise;
    logic [9:0]  gate_ratio;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_HOLD, OP_CLEAR, OP_LOAD, OP_FIRST, OP_GROW, OP_PSQ, OP_MM,
    OP_MC, OP_ZERO, OP_DIV, OP_PO, OP_SQ, OP_SQR, OP_WRITE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             accept;
    logic [1:0]       ch;
    logic [5:0]       cnt;
    logic [PT_AW-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic first;
    logic d_zero;
  } stat_t;

endpackage

>>> rtl/pcbf_ram.sv
// generic simple dual-port ram with registered read
module pcbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/pcbf_dp.sv
// datapath: point table, gate, prediction, shared divider and square root
module pcbf_dp import pcbf_pkg::*; (
  input  logic             clk,
  input  cmd_t             cmd,
  input  cfg_t             cfg,
  input  logic [IN_W-1:0]  in_data,
  output stat_t            stat,
  output logic [OUT_W-1:0] out_data
);

  logic [PT_AW-1:0]    idx_r;
  logic [2:0][7:0]     col_r;
  logic [23:0]         vdist_r;
  logic [31:0]         otime_r;
  entry_t              ent_r;
  logic [1:0]          res_r;
  logic [38:0]         grow_r;
  logic [31:0]         osq_r;
  logic [31:0]         psq_r;
  logic [47:0]         acc_r;
  logic [32:0]         d_r;
  logic [63:0]         num_r;
  logic [64:0]         div_r;
  logic [31:0]         quo_r;
  logic [15:0]         root_r;
  logic [OUT_W-1:0]    out_r;

  logic                ram_we;
  logic [PT_AW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_q;

  logic [33:0] gate_rhs;
  logic [31:0] dt;
  logic [47:0] grow_prod;
  logic [48:0] grow_sum;
  logic [15:0] s_cur, m_cur, c8, p_sat, cand;
  logic [39:0] p_full;
  logic [47:0] cp_prod;
  logic [63:0] mc_sum;
  logic [63:0] po_prod;
  logic        div_ge;
  logic [64:0] div_sub;
  logic [31:0] cand_sq, root_sq;
  logic [32:0] root_lim;
  logic [3:0]  bit_pos;

  assign ram_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE);
  assign ram_waddr = (cmd.op == OP_CLEAR) ? cmd.clr_addr : idx_r;
  assign ram_wdata = (cmd.op == OP_CLEAR) ? '0 : ENTRY_W'(ent_r);

  pcbf_ram #(.WIDTH(ENTRY_W), .DEPTH(POINT_COUNT)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_data[PT_AW-1:0]),
    .rdata (ram_q)
  );

  // gate and decision flags
  assign gate_rhs    = ent_r.near_dist * cfg.gate_ratio;
  assign stat.reject = (ent_r.near_dist != 24'd0) && ({2'b00, vdist_r, 8'h00} > gate_rhs);
  assign stat.first  = (ent_r.count == 16'd0);
  assign stat.d_zero = (d_r == 33'd0);

  // sigma growth over elapsed time, time wraps
  assign dt        = otime_r - ent_r.last_time;
  assign grow_prod = cfg.proc_noise * dt;
  assign grow_sum  = {1'b0, grow_prod} + 49'd512;

  assign s_cur  = ent_r.sigma[cmd.ch];
  assign m_cur  = ent_r.color[cmd.ch];
  assign c8     = {col_r[cmd.ch], 8'h00};
  assign p_full = {24'd0, s_cur} + {1'b0, grow_r};
  assign p_sat  = (p_full[39:16] != 24'd0) ? 16'hFFFF : p_full[15:0];

  assign cp_prod = c8 * psq_r;
  assign mc_sum  = {16'd0, acc_r} + {16'd0, cp_prod} + {32'd0, d_r[32:1]};
  assign po_prod = psq_r * osq_r;

  // one restoring step of the shared divider
  assign div_ge  = {1'b0, num_r} >= div_r;
  assign div_sub = {1'b0, num_r} - div_r;

  // one bit of the square root per step, msb first
  assign bit_pos  = 4'(ROOT_BITS - 1) - cmd.cnt[3:0];
  assign cand     = root_r | (16'd1 << bit_pos);
  assign cand_sq  = cand * cand;
  assign root_sq  = root_r * root_r;
  assign root_lim = {1'b0, root_sq} + {17'd0, root_r};

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_HOLD: begin
        if (cmd.accept) begin
          idx_r    <= in_data[PT_AW-1:0];
          col_r[0] <= in_data[19:12];
          col_r[1] <= in_data[27:20];
          col_r[2] <= in_data[35:28];
          vdist_r  <= in_data[59:36];
          otime_r  <= in_data[91:60];
        end
      end
      OP_LOAD: begin
        ent_r <= entry_t'(ram_q);
        res_r <= RES_REJECT;
      end
      OP_FIRST: begin
        for (int i = 0; i < CHANNELS; i++) begin
          ent_r.color[i] <= {col_r[i], 8'h00};
          ent_r.sigma[i] <= cfg.meas_sigma;
        end
        ent_r.near_dist <= vdist_r;
        ent_r.last_time <= otime_r;
        ent_r.count     <= 16'd1;
        res_r           <= RES_FIRST;
      end
      OP_GROW: begin
        grow_r <= grow_sum[48:10];
        osq_r  <= cfg.meas_sigma * cfg.meas_sigma;
        if (vdist_r < ent_r.near_dist) begin
          ent_r.near_dist <= vdist_r;
        end
        ent_r.last_time <= otime_r;
        if (ent_r.count != 16'hFFFF) begin
          ent_r.count <= ent_r.count + 16'd1;
        end
        res_r <= RES_FUSED;
      end
      OP_PSQ: psq_r <= p_sat * p_sat;
      OP_MM: begin
        acc_r <= m_cur * osq_r;
        d_r   <= {1'b0, psq_r} + {1'b0, osq_r};
      end
      OP_MC: begin
        num_r <= mc_sum;
        div_r <= {32'd0, d_r} << (COLOR_QBITS - 1);
        quo_r <= '0;
      end
      OP_ZERO: ent_r.sigma[cmd.ch] <= 16'd0;
      OP_DIV: begin
        if (div_ge) begin
          num_r <= div_sub[63:0];
        end
        quo_r <= {quo_r[30:0], div_ge};
        div_r <= div_r >> 1;
      end
      OP_PO: begin
        ent_r.color[cmd.ch] <= quo_r[15:0];
        num_r  <= po_prod;
        div_r  <= {32'd0, d_r} << (SIGMA_QBITS - 1);
        quo_r  <= '0;
        root_r <= '0;
      end
      OP_SQ: begin
        if (cand_sq <= quo_r) begin
          root_r <= cand;
        end
      end
      OP_SQR: begin
        // round to nearest, wraps to zero at the very top as a 16-bit store
        ent_r.sigma[cmd.ch] <= ({1'b0, quo_r} > root_lim) ? root_r + 16'd1 : root_r;
      end
      OP_WRITE: begin
        out_r <= {6'd0, ent_r.count, ent_r.color[2], ent_r.color[1], ent_r.color[0], res_r};
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

>>> rtl/pcbf_ctrl.sv
// controller: clearing sweep, item sequencing and result register valid
module pcbf_ctrl import pcbf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output logic  in_ready,
  output logic  out_valid,
  output cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_CLEAR  = 15'h0001,
    S_IDLE   = 15'h0002,
    S_LOAD   = 15'h0004,
    S_DECIDE = 15'h0008,
    S_FIRST  = 15'h0010,
    S_GROW   = 15'h0020,
    S_PSQ    = 15'h0040,
    S_MM     = 15'h0080,
    S_MC     = 15'h0100,
    S_DIVC   = 15'h0200,
    S_PO     = 15'h0400,
    S_DIVQ   = 15'h0800,
    S_SQ     = 15'h1000,
    S_SQR    = 15'h2000,
    S_WRITE  = 15'h4000
  } state_t;

  state_t           state_r, state_nxt;
  logic [PT_AW-1:0] clr_r, clr_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_HOLD;
    cmd.accept    = 1'b0;
    cmd.ch        = ch_r;
    cmd.cnt       = cnt_r;
    cmd.clr_addr  = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op  = OP_CLEAR;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == PT_AW'(POINT_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.op    = OP_LOAD;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.reject)     state_nxt = S_WRITE;
        else if (stat.first) state_nxt = S_FIRST;
        else                 state_nxt = S_GROW;
      end
      S_FIRST: begin
        cmd.op    = OP_FIRST;
        state_nxt = S_WRITE;
      end
      S_GROW: begin
        cmd.op    = OP_GROW;
        ch_nxt    = 2'd0;
        state_nxt = S_PSQ;
      end
      S_PSQ: begin
        cmd.op    = OP_PSQ;
        state_nxt = S_MM;
      end
      S_MM: begin
        cmd.op    = OP_MM;
        state_nxt = S_MC;
      end
      S_MC: begin
        cnt_nxt = 6'd0;
        if (stat.d_zero) begin
          cmd.op = OP_ZERO;
          if (ch_r == 2'(CHANNELS - 1)) state_nxt = S_WRITE;
          else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = S_PSQ;
          end
        end else begin
          cmd.op    = OP_MC;
          state_nxt = S_DIVC;
        end
      end
      S_DIVC: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(COLOR_QBITS - 1)) state_nxt = S_PO;
      end
      S_PO: begin
        cmd.op    = OP_PO;
        cnt_nxt   = 6'd0;
        state_nxt = S_DIVQ;
      end
      S_DIVQ: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(SIGMA_QBITS - 1)) begin
          cnt_nxt   = 6'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op  = OP_SQ;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(ROOT_BITS - 1)) state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.op = OP_SQR;
        if (ch_r == 2'(CHANNELS - 1)) state_nxt = S_WRITE;
        else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_PSQ;
        end
      end
      S_WRITE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_WRITE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/point_color_bayes_fusion.sv
// top level of the per-point colour fusion block
// after reset the point table is swept to zero, one entry a cycle; no transfer is taken meanwhile
// a rejected item passes load, decide and write; a first observation load, decide, first and write
// a fused item passes load, decide and grow, then per channel a 16-step and a 32-step division
// and a 16-step square root on shared iterative units, three channels in turn, none if d_r is zero
// one item at a time, no transfer until its result is written; a waiting result frees the input
module point_color_bayes_fusion import pcbf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // observation stream
  input  logic              in_tvalid,
  output logic              in_tready,
  // point_index, color_0, color_1, color_2, view_distance, observation time
  input  logic [IN_W-1:0]   in_tdata,
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  // status, fused_0, fused_1, fused_2, view_count
  output logic [OUT_W-1:0]  out_tdata
);

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.meas_sigma <= OBS_SIGMA_RST;
      cfg_r.proc_noise <= PROC_NOISE_RST;
      cfg_r.gate_ratio <= GATE_RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OBS_SIGMA:  cfg_r.meas_sigma <= cfg_wdata;
        CFG_PROC_NOISE: cfg_r.proc_noise <= cfg_wdata;
        CFG_GATE_RATIO: cfg_r.gate_ratio <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // sequencing of the per-item steps
  pcbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  // table, arithmetic and result register
  pcbf_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .in_data  (in_tdata),
    .stat     (stat),
    .out_data (out_tdata)
  );

`ifndef SYNTHESIS
  // one item at a time: an input transfer closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken twice in a row");

  // no unused status code reaches the output
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("bad status code");

  // an accepted observation always leaves a non-zero count
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] != RES_REJECT)) |-> (out_tdata[65:50] != 16'd0))
    else $error("zero count on accepted observation");
`endif

endmodule

>>> dv/tb_point_color_bayes_fusion.sv
// testbench of the point colour fusion block: directed and random observations against a predictor
`timescale 1ns / 1ps

module tb_point_color_bayes_fusion import pcbf_pkg::*;;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  // point_index [11:0], color_0 [19:12], color_1 [27:20], color_2 [35:28],
  // view_distance [59:36], timestamp [91:60], zero fill [95:92]
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  // status [1:0], fused_0 [17:2], fused_1 [33:18], fused_2 [49:34],
  // view_count [65:50], zero fill [71:66]
  logic [OUT_W-1:0]  out_tdata;

  typedef struct packed {
    logic [1:0]       status;
    logic [2:0][15:0] color;
    logic [15:0]      count;
  } fusion_res_t;

  // predictor copy of the point table and the registers
  logic [15:0] pt_color [POINT_COUNT][3];
  logic [15:0] pt_sigma [POINT_COUNT][3];
  logic [23:0] pt_dist  [POINT_COUNT];
  logic [31:0] pt_time  [POINT_COUNT];
  logic [15:0] pt_views [POINT_COUNT];
  logic [15:0] meas_sigma;
  logic [15:0] proc_noise;
  logic [9:0]  gate_ratio;

  fusion_res_t pending_res[$];
  int          mismatch_cnt = 0;
  bit          send_idle_en;
  bit          recv_idle_en;

  point_color_bayes_fusion dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous fixed limit, well above the slowest legal run
  initial begin
    #(64'd12 * 64'd8_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 90);
  endfunction

  // rounded integer square root
  function automatic longint unsigned root_round(longint unsigned q);
    longint unsigned r;
    longint unsigned cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= q) r = cand;
    end
    if (q > r * r + r) r++;
    return r;
  endfunction

  // one observation applied to the predictor table, returns the expected result
  function automatic fusion_res_t fuse_obs(logic [11:0] idx, logic [2:0][7:0] c,
                                           logic [23:0] vdist, logic [31:0] t);
    fusion_res_t     res;
    longint unsigned dt, p, pp, oo, dd, m, cc;
    if (pt_dist[idx] != 0 &&
        ({40'd0, vdist} << 8) > longint'(pt_dist[idx]) * longint'(gate_ratio)) begin
      res.status = RES_REJECT;
    end else if (pt_views[idx] == 0) begin
      for (int ch = 0; ch < 3; ch++) begin
        pt_color[idx][ch] = {c[ch], 8'd0};
        pt_sigma[idx][ch] = meas_sigma;
      end
      pt_dist[idx]  = vdist;
      pt_time[idx]  = t;
      pt_views[idx] = 16'd1;
      res.status    = RES_FIRST;
    end else begin
      dt = 64'(32'(t - pt_time[idx]));
      for (int ch = 0; ch < 3; ch++) begin
        p = 64'(pt_sigma[idx][ch]) + ((longint'(proc_noise) * dt + 512) >> 10);
        if (p > 65535) p = 65535;
        pp = p * p;
        oo = longint'(meas_sigma) * longint'(meas_sigma);
        dd = pp + oo;
        if (dd == 0) begin
          // both sigmas zero: colour held, sigma zero
          pt_sigma[idx][ch] = 16'd0;
        end else begin
          m  = 64'(pt_color[idx][ch]);
          cc = longint'(c[ch]) << 8;
          pt_color[idx][ch] = 16'((m * oo + cc * pp + dd / 2) / dd);
          pt_sigma[idx][ch] = 16'(root_round((pp * oo) / dd));
        end
      end
      if (vdist < pt_dist[idx]) pt_dist[idx] = vdist;
      pt_time[idx] = t;
      if (pt_views[idx] != 16'hFFFF) pt_views[idx]++;
      res.status = RES_FUSED;
    end
    for (int ch = 0; ch < 3; ch++) res.color[ch] = pt_color[idx][ch];
    res.count = pt_views[idx];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_cnt++;
  endtask

  // result side: random stall, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    fusion_res_t want;
    int          stall;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_res.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", 32'(out_tdata[1:0]), 32'(want.status));
        for (int ch = 0; ch < 3; ch++)
          if (out_tdata[2 + 16*ch +: 16] !== want.color[ch])
            report_mismatch($sformatf("fused_%0d", ch), 32'(out_tdata[2 + 16*ch +: 16]),
                            32'(want.color[ch]));
        if (out_tdata[65:50] !== want.count)
          report_mismatch("view_count", 32'(out_tdata[65:50]), 32'(want.count));
      end
    end
    stall = recv_idle_en ? gap_len() : 0;
    out_tready <= (stall == 0);
  end

  // one observation transfer; in_tvalid stays high if no gap follows
  task automatic send_obs(logic [11:0] idx, logic [2:0][7:0] c, logic [23:0] vdist,
                          logic [31:0] t);
    int gap;
    in_tdata  <= {4'd0, t, vdist, c[2], c[1], c[0], idx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_res = {pending_res, fuse_obs(idx, c, vdist, t)};
    gap = send_idle_en ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every expected result drain
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (addr)
      CFG_OBS_SIGMA:  meas_sigma = val;
      CFG_PROC_NOISE: proc_noise = val;
      CFG_GATE_RATIO: gate_ratio = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] sig, logic [15:0] noise, logic [9:0] gate);
    write_reg(CFG_OBS_SIGMA, sig);
    write_reg(CFG_PROC_NOISE, noise);
    write_reg(CFG_GATE_RATIO, {6'd0, gate});
  endtask

  // field extremes, gate rejection, time running backwards with saturation
  task automatic test_extremes();
    send_obs(12'd0, {8'd0, 8'd0, 8'd0}, 24'hFFFFFF, 32'd0);
    send_obs(12'd4095, {8'd255, 8'd255, 8'd255}, 24'd1, 32'hFFFFFFFF);
    send_obs(12'd0, {8'd255, 8'd255, 8'd255}, 24'd1000, 32'd1024);
    send_obs(12'd0, {8'd0, 8'd255, 8'd0}, 24'd1000, 32'd3000);
    // far beyond the gate
    send_obs(12'd0, {8'd9, 8'd9, 8'd9}, 24'hFFFFFF, 32'd4000);
    // inside the gate, then one step past it
    send_obs(12'd4095, {8'd1, 8'd2, 8'd3}, 24'd1, 32'd5);
    send_obs(12'd4095, {8'd0, 8'd128, 8'd255}, 24'd2, 32'd10);
    // time going backwards wraps dt
    send_obs(12'd0, {8'd10, 8'd20, 8'd30}, 24'd900, 32'd100);
    send_obs(12'd2048, {8'hAA, 8'h55, 8'hAA}, 24'h800000, 32'h55555555);
    send_obs(12'd2048, {8'h55, 8'hAA, 8'h55}, 24'h7FFFFF, 32'hAAAAAAAA);
    wait_drained();
    // maximum noise drives sigma to saturation
    set_regs(16'd65535, 16'd65535, 10'd1023);
    send_obs(12'd0, {8'd200, 8'd100, 8'd50}, 24'd1200, 32'hF0000000);
    send_obs(12'd2048, {8'd7, 8'd8, 8'd9}, 24'hFFFFFF, 32'h00000001);
    send_obs(12'd1365, {8'd1, 8'd1, 8'd1}, 24'd5, 32'd0);
    send_obs(12'd1365, {8'd254, 8'd254, 8'd254}, 24'd5, 32'd0);
    wait_drained();
  endtask

  // zero observation sigma and zero process noise, alone and together
  task automatic test_zero_sigma();
    set_regs(16'd0, 16'd0, 10'd307);
    send_obs(12'd100, {8'd40, 8'd80, 8'd120}, 24'd500, 32'd0);
    send_obs(12'd100, {8'd200, 8'd10, 8'd0}, 24'd500, 32'd50);
    send_obs(12'd101, {8'd40, 8'd80, 8'd120}, 24'd500, 32'd0);
    wait_drained();
    // observation sigma zero alone takes the observation
    set_regs(16'd0, 16'd300, 10'd307);
    send_obs(12'd101, {8'd250, 8'd5, 8'd60}, 24'd500, 32'd4096);
    wait_drained();
    // stored sigma zero with no noise keeps the stored colour
    set_regs(16'd1, 16'd0, 10'd307);
    send_obs(12'd100, {8'd1, 8'd2, 8'd3}, 24'd400, 32'd60);
    wait_drained();
  endtask

  // gate ratio below unity rejects even a closer view
  task automatic test_low_gate();
    set_regs(16'd3840, 16'd26, 10'd128);
    send_obs(12'd300, {8'd60, 8'd60, 8'd60}, 24'd1000, 32'd0);
    send_obs(12'd300, {8'd90, 8'd90, 8'd90}, 24'd900, 32'd10);
    send_obs(12'd300, {8'd90, 8'd90, 8'd90}, 24'd400, 32'd20);
    wait_drained();
  endtask

  // random observations: mostly a small pool of points with plausible distances,
  // some wide noise items over the whole table and field ranges
  task automatic test_random(int n_items, int pool_base);
    logic [11:0]      idx;
    logic [2:0][7:0]  c;
    logic [23:0]      vdist;
    logic [31:0]      t;
    longint unsigned  d;
    for (int i = 0; i < n_items; i++) begin
      c = {8'($urandom), 8'($urandom), 8'($urandom)};
      if ($urandom_range(0, 9) == 0) begin
        idx   = 12'($urandom);
        vdist = 24'($urandom_range(1, 24'hFFFFFF));
        t     = $urandom;
      end else begin
        idx = 12'(pool_base + $urandom_range(0, 39));
        if (pt_views[idx] == 0) begin
          vdist = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 24'hFFFFFF))
                                              : 24'($urandom_range(256, 8192));
          t = $urandom;
        end else begin
          d = (longint'(pt_dist[idx]) * $urandom_range(100, 420)) >> 8;
          if (d == 0) d = 1;
          if (d > 24'hFFFFFF) d = 24'hFFFFFF;
          vdist = 24'(d);
          t = ($urandom_range(0, 19) == 0) ? $urandom
                                           : pt_time[idx] + $urandom_range(0, 20000);
        end
      end
      send_obs(idx, c, vdist, t);
      if (i % 150 == 149) begin
        send_idle_en = $urandom_range(0, 3) != 0;
        recv_idle_en = $urandom_range(0, 3) != 0;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    meas_sigma   = OBS_SIGMA_RST;
    proc_noise   = PROC_NOISE_RST;
    gate_ratio   = GATE_RATIO_RST;
    for (int i = 0; i < POINT_COUNT; i++) begin
      pt_dist[i]  = '0;
      pt_views[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_zero_sigma();
    test_low_gate();
    set_regs(OBS_SIGMA_RST, PROC_NOISE_RST, GATE_RATIO_RST);
    test_random(430, 400);
    set_regs(16'd1, 16'd65535, 10'd256);
    test_random(430, 500);
    set_regs(16'd65535, 16'd0, 10'd1023);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random(430, 600);
    set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 4000)),
             10'($urandom_range(256, 1023)));
    test_random(430, 700);

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pcbf_pkg.sv
rtl/pcbf_ram.sv
rtl/pcbf_dp.sv
rtl/pcbf_ctrl.sv
rtl/point_color_bayes_fusion.sv
dv/tb_point_color_bayes_fusion.sv
